>>> src/fsf_pkg.sv
// Shared constants for the free slot finder: field widths, day length default
// and the configuration register map. No dependencies.
`default_nettype none

package fsf_pkg;

    localparam int MINUTES_PER_DAY_DEF = 1440;
    localparam int MINUTES_PER_HOUR    = 60;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SLOT_W   = 11;
    localparam int LEN_W    = 11;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_MIN_LENGTH = 2'd0;

    localparam logic OP_MARK = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef logic [HOUR_W-1:0]   hour_t;
    typedef logic [MINUTE_W-1:0] minute_t;
    typedef logic [SLOT_W-1:0]   slot_t;

endpackage

`default_nettype wire

>>> src/free_slot_finder.sv
// Free slot finder top level: minute busy map, mark and find sequencer, APB register.
// Depends on fsf_pkg.
//
// One busy bit per minute of the day lives in a single-port memory that is walked
// one minute per cycle. After reset a clearing pass writes every entry free, with
// s_tready low meanwhile (register writes are taken). A mark request writes the
// minutes from start up to but not including end, and none when end is not after start.
// A find request reads the map from the search start onward, one bit per cycle
// through the registered memory read, and stops at the minute that closes the
// qualifying run or at the end of day. One request is worked at a time; a finished
// result waits in the output register while the next request proceeds.
`default_nettype none

module free_slot_finder #(
    parameter int MINUTES_PER_DAY = fsf_pkg::MINUTES_PER_DAY_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    // s_tdata: start_hour[4:0], start_minute[10:5], end_hour[15:11],
    //          end_minute[21:16], zero pad [23:22]
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    input  wire  [fsf_pkg::IN_TDATA_W-1:0]         s_tdata,
    // s_tuser: operation[0]
    input  wire                                    s_tuser,
    // m_tdata: slot_start[10:0], slot_end[21:11], zero pad [23:22]
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    output logic [fsf_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // m_tuser: found[0]
    output logic                                   m_tuser,
    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire  [fsf_pkg::APB_ADDR_W-1:0]         paddr,
    input  wire  [fsf_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [fsf_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int AW = $clog2(MINUTES_PER_DAY + 1);
    localparam int IW = $clog2(MINUTES_PER_DAY);
    localparam int CW = (AW > fsf_pkg::SLOT_W) ? AW : fsf_pkg::SLOT_W;
    localparam logic [AW-1:0] DAY_END  = AW'(MINUTES_PER_DAY);
    localparam logic [AW-1:0] LAST_MIN = AW'(MINUTES_PER_DAY - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [AW-1:0]                end_reg, end_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic                         dv_reg, dv_next;
    logic                         in_run_reg, in_run_next;
    logic [AW-1:0]                run_start_reg, run_start_next;
    logic                         found_reg, found_next;
    logic [AW-1:0]                res_start_reg, res_start_next;
    logic [AW-1:0]                res_end_reg, res_end_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_found_reg, m_found_next;
    fsf_pkg::slot_t               m_start_reg, m_start_next;
    fsf_pkg::slot_t               m_end_reg, m_end_next;
    logic [fsf_pkg::LEN_W-1:0]    min_length_reg;

    logic                         busy_map [MINUTES_PER_DAY];
    logic                         rdata_reg;
    logic                         mem_we;
    logic                         mem_wdata;
    logic                         rd_en;

    fsf_pkg::hour_t               in_start_hour, in_end_hour;
    fsf_pkg::minute_t             in_start_minute, in_end_minute;
    logic [AW-1:0]                start_min, end_min;
    logic                         accept;
    logic                         at_end;
    logic                         long_enough;
    logic [AW-1:0]                run_len;

    function automatic logic [AW-1:0] to_minutes(input fsf_pkg::hour_t hour,
                                                 input fsf_pkg::minute_t minute);
        logic [fsf_pkg::SLOT_W-1:0] raw;
        raw = fsf_pkg::SLOT_W'(hour) * fsf_pkg::SLOT_W'(fsf_pkg::MINUTES_PER_HOUR)
            + fsf_pkg::SLOT_W'(minute);
        if (CW'(raw) > CW'(MINUTES_PER_DAY))
        begin
            return DAY_END;
        end
        return AW'(raw);
    endfunction

    assign in_start_hour   = s_tdata[4:0];
    assign in_start_minute = s_tdata[10:5];
    assign in_end_hour     = s_tdata[15:11];
    assign in_end_minute   = s_tdata[21:16];

    assign start_min = to_minutes(in_start_hour, in_start_minute);
    assign end_min   = to_minutes(in_end_hour, in_end_minute);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(fsf_pkg::OUT_TDATA_W - 2 * fsf_pkg::SLOT_W){1'b0}},
                       m_end_reg, m_start_reg};

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == fsf_pkg::REG_MIN_LENGTH)
                  ? fsf_pkg::APB_DATA_W'(min_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == fsf_pkg::REG_MIN_LENGTH))
        begin
            min_length_reg <= pwdata[fsf_pkg::LEN_W-1:0];
        end
    end

    // busy map memory
    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_MARK);
    assign mem_wdata = (state_reg == S_MARK);
    assign rd_en     = (state_reg == S_FIND) && (ptr_reg != DAY_END);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            busy_map[ptr_reg[IW-1:0]] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= busy_map[ptr_reg[IW-1:0]];
        end
    end

    // run evaluation on the bit returned from the map
    assign at_end      = (pos_reg == DAY_END);
    assign run_len     = pos_reg - run_start_reg;
    assign long_enough = in_run_reg && (CW'(run_len) >= CW'(min_length_reg));

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        pos_next       = pos_reg;
        dv_next        = dv_reg;
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        found_next     = found_reg;
        res_start_next = res_start_reg;
        res_end_next   = res_end_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_found_next   = m_found_reg;
        m_start_next   = m_start_reg;
        m_end_next     = m_end_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_MIN)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ptr_next = start_min;
                    end_next = end_min;
                    if (s_tuser == fsf_pkg::OP_FIND)
                    begin
                        dv_next     = 1'b0;
                        in_run_next = 1'b0;
                        state_next  = S_FIND;
                    end
                    else if (end_min > start_min)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_next == end_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIND:
            begin
                pos_next = ptr_reg;
                dv_next  = 1'b1;
                if (ptr_reg != DAY_END)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    if (at_end || rdata_reg)
                    begin
                        in_run_next = 1'b0;
                        if (long_enough)
                        begin
                            found_next     = 1'b1;
                            res_start_next = run_start_reg;
                            res_end_next   = pos_reg;
                            state_next     = S_WAIT;
                        end
                        else if (at_end)
                        begin
                            found_next     = 1'b0;
                            res_start_next = '0;
                            res_end_next   = '0;
                            state_next     = S_WAIT;
                        end
                    end
                    else if (!in_run_reg)
                    begin
                        in_run_next    = 1'b1;
                        run_start_next = pos_reg;
                    end
                end
            end
            S_WAIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = found_reg;
                    m_start_next  = fsf_pkg::SLOT_W'(res_start_reg);
                    m_end_next    = fsf_pkg::SLOT_W'(res_end_reg);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ptr_reg      <= '0;
            dv_reg       <= 1'b0;
            in_run_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            dv_reg       <= dv_next;
            in_run_reg   <= in_run_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg       <= end_next;
        pos_reg       <= pos_next;
        run_start_reg <= run_start_next;
        found_reg     <= found_next;
        res_start_reg <= res_start_next;
        res_end_reg   <= res_end_next;
        m_found_reg   <= m_found_next;
        m_start_reg   <= m_start_next;
        m_end_reg     <= m_end_next;
    end

endmodule

`default_nettype wire
